@@ hdl/ir_ternary_pulse_distance_encoder_defines.svh @@
// assertion macros for the encoder rtl
`ifndef IR_TERNARY_PULSE_DISTANCE_ENCODER_DEFINES_SVH
`define IR_TERNARY_PULSE_DISTANCE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ITE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ITE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ite_pkg.sv @@
// types, constants and decode functions of the pulse-distance encoder
`default_nettype none
package ite_pkg;

	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned IDX_W   = 3;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_CHAR  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;

	localparam logic [7:0] MARK_BYTE  = 8'h00;
	localparam logic [7:0] SPACE_BYTE = 8'hFF;

	localparam logic [LEN_W-1:0] HDR_MARK   = 6'd32;
	localparam logic [LEN_W-1:0] HDR_SPACE  = 6'd16;
	localparam logic [LEN_W-1:0] BIT_MARK   = 6'd4;
	localparam logic [LEN_W-1:0] SPACE_D0   = 6'd4;
	localparam logic [LEN_W-1:0] SPACE_D1   = 6'd8;
	localparam logic [LEN_W-1:0] SPACE_D2   = 6'd12;
	localparam logic [LEN_W-1:0] TRAIL_MARK = 6'd4;

	localparam logic [4:0] BLANK_CODE = 5'd26;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd3000;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// requests from the sequencer to the byte counter
	typedef struct packed {
		logic clear;
		logic step;
	} cnt_ctrl_t;

	// byte counter view of the limit
	typedef struct packed {
		logic room;
		logic final_byte;
	} cnt_status_t;

	// {valid, code}: letters to 0..25, blank to 26
	function automatic logic [5:0] char_to_code(input logic [7:0] ch);
		logic [7:0] diff;
		diff = 8'h00;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			diff = ch - 8'h41;
			return {1'b1, diff[4:0]};
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			diff = ch - 8'h61;
			return {1'b1, diff[4:0]};
		end else if (ch == 8'h20) begin
			return {1'b1, BLANK_CODE};
		end
		return 6'd0;
	endfunction

	// three base-3 digits, most significant in the top pair
	function automatic logic [5:0] code_digits(input logic [4:0] code);
		logic [1:0] d0;
		logic [1:0] d1;
		logic [1:0] d2;
		logic [4:0] r;
		if (code >= 5'd18) begin
			d0 = 2'd2;
			r  = code - 5'd18;
		end else if (code >= 5'd9) begin
			d0 = 2'd1;
			r  = code - 5'd9;
		end else begin
			d0 = 2'd0;
			r  = code;
		end
		if (r >= 5'd6) begin
			d1 = 2'd2;
			r  = r - 5'd6;
		end else if (r >= 5'd3) begin
			d1 = 2'd1;
			r  = r - 5'd3;
		end else begin
			d1 = 2'd0;
		end
		d2 = r[1:0];
		return {d0, d1, d2};
	endfunction

	function automatic logic [LEN_W-1:0] space_len(input logic [1:0] d);
		case (d)
			2'd0:    return SPACE_D0;
			2'd1:    return SPACE_D1;
			default: return SPACE_D2;
		endcase
	endfunction

	// length of run idx for the item kind; even runs are marks, odd are spaces
	function automatic logic [LEN_W-1:0] run_len(input logic [1:0] kind,
			input logic [IDX_W-1:0] idx, input logic [5:0] digits);
		logic [1:0] d;
		case (idx[2:1])
			2'd0:    d = digits[5:4];
			2'd1:    d = digits[3:2];
			default: d = digits[1:0];
		endcase
		case (kind)
			ACT_START: return (idx == '0) ? HDR_MARK : HDR_SPACE;
			ACT_CHAR:  return idx[0] ? space_len(d) : BIT_MARK;
			default:   return TRAIL_MARK;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] last_run(input logic [1:0] kind);
		case (kind)
			ACT_START: return 3'd1;
			ACT_CHAR:  return 3'd5;
			default:   return 3'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ hdl/ite_limit.sv @@
// byte counter with limit register and the shared limit compare
`default_nettype none
module ite_limit
	import ite_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_data,
	input  wire cnt_ctrl_t          ctrl,
	output cnt_status_t             status
);

	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] sent_q;
	logic [LIMIT_W:0]   sent_inc;

	assign sent_inc = {1'b0, sent_q} + {{LIMIT_W{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			sent_q  <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (ctrl.clear) begin
				sent_q <= '0;
			end else if (ctrl.step) begin
				sent_q <= sent_inc[LIMIT_W-1:0];
			end
		end
	end

	assign status.room       = sent_q < limit_q;
	// this byte fills the budget, nothing more may follow
	assign status.final_byte = sent_inc == {1'b0, limit_q};

endmodule
`default_nettype wire

@@ hdl/ite_seq.sv @@
// run sequencer: walks the mark and space runs of one item, one byte a cycle while the output is free
`default_nettype none
module ite_seq
	import ite_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  char_code,
	output logic             in_ready,
	input  wire logic        out_free,
	input  wire cnt_status_t status,
	output cnt_ctrl_t        ctrl,
	output logic             emit,
	output logic [7:0]       line_byte,
	output logic             last
);

	state_t               state_q, state_d;
	logic [1:0]           kind_q, kind_d;
	logic [5:0]           digits_q, digits_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [LEN_W-1:0]     left_q, left_d;
	logic [5:0]           decoded;
	logic [IDX_W-1:0]     idx_next;
	logic                 last_of_item;

	assign decoded  = char_to_code(char_code);
	assign idx_next = idx_q + 3'd1;
	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		digits_q <= digits_d;
		idx_q    <= idx_d;
		left_q   <= left_d;
	end

	assign line_byte    = idx_q[0] ? SPACE_BYTE : MARK_BYTE;
	assign last_of_item = (idx_q == last_run(kind_q)) && (left_q == 6'd1);
	assign last         = last_of_item || status.final_byte;

	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		digits_d   = digits_q;
		idx_d      = idx_q;
		left_d     = left_q;
		ctrl.clear = 1'b0;
		ctrl.step  = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_d   = action;
					digits_d = code_digits(decoded[4:0]);
					idx_d    = '0;
					left_d   = run_len(action, '0, 6'd0);
					case (action)
						ACT_START: begin
							ctrl.clear = 1'b1;
							state_d    = ST_RUN;
						end
						ACT_CHAR: begin
							if (decoded[5]) begin
								state_d = ST_RUN;
							end
						end
						ACT_END: begin
							state_d = ST_RUN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RUN: begin
				if (out_free) begin
					if (!status.room) begin
						state_d = ST_IDLE;
					end else begin
						emit      = 1'b1;
						ctrl.step = 1'b1;
						if (last) begin
							state_d = ST_IDLE;
						end else if (left_q == 6'd1) begin
							idx_d  = idx_next;
							left_d = run_len(kind_q, idx_next, digits_q);
						end else begin
							left_d = left_q - 6'd1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/ir_ternary_pulse_distance_encoder.sv @@
// Infrared pulse-distance encoder: turns start, character and end items into a
// byte stream of marks (0x00) and spaces (0xFF) for a serial line. A start item
// gives 48 bytes, a letter or blank 24 to 48 bytes, an end item 4 bytes; the run
// sequencer steps one byte counter and emits one byte a cycle while tready
// allows, and it takes no new item until the current one is through. Unknown
// characters and action 3 are taken and emit nothing; an item that meets an
// already spent limit emits nothing. Bytes past the limit register are dropped
// and tlast moves to the final byte that was sent. The output register lets the
// next byte wait for tready.
`default_nettype none
`include "ir_ternary_pulse_distance_encoder_defines.svh"
module ir_ternary_pulse_distance_encoder
	import ite_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_data,  // buffer_limit
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // char_code
	input  wire logic [1:0]         s_tuser,   // action
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,   // line_byte
	output logic                    m_tlast
);

	cnt_ctrl_t   ctrl;
	cnt_status_t status;
	logic        out_free;
	logic        emit;
	logic [7:0]  line_byte;
	logic        last;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic        m_tlast_q;

	ite_limit u_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.status   (status)
	);

	ite_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.action    (s_tuser),
		.char_code (s_tdata),
		.in_ready  (s_tready),
		.out_free  (out_free),
		.status    (status),
		.ctrl      (ctrl),
		.emit      (emit),
		.line_byte (line_byte),
		.last      (last)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= line_byte;
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// a byte is only produced while an item is in progress and the budget allows
	`ITE_ASSERT_IMP(a_emit_busy, clk, arst_n, emit, !s_tready, "byte emitted while idle")
	`ITE_ASSERT_IMP(a_emit_room, clk, arst_n, emit, status.room, "byte emitted past limit")
	// the final beat of an item frees the input side
	`ITE_ASSERT_NXT(a_last_idle, clk, arst_n, emit && last, s_tready, "busy after last beat")

endmodule
`default_nettype wire

@@ verif/tb_ir_ternary_pulse_distance_encoder.sv @@
// self-checking testbench for the infrared pulse-distance encoder
`timescale 1ns / 100ps
module tb_ir_ternary_pulse_distance_encoder;
	import ite_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [7:0]  LINE_MARK       = 8'h00;
	localparam logic [7:0]  LINE_SPACE      = 8'hFF;
	localparam int unsigned HEADER_MARK_LEN = 32;
	localparam int unsigned HEADER_GAP_LEN  = 16;
	localparam int unsigned DIGIT_MARK_LEN  = 4;
	localparam int unsigned DIGIT_GAP_STEP  = 4;
	localparam int unsigned TRAILER_LEN     = 4;
	localparam int unsigned BLANK_INDEX     = 26;
	localparam logic [11:0] LIMIT_AT_RESET  = 12'd3000;

	localparam int unsigned MAX_WAIT     = 16;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT  = 1500000;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
	} msg_item_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       last;
	} line_beat_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic [11:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	msg_item_t   pending_q[$];
	line_beat_t  line_q[$];

	logic [11:0] line_limit = LIMIT_AT_RESET;
	logic [11:0] sent_count = '0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned src_gap = 0;
	int unsigned sink_stall = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	msg_item_t   next_item;
	line_beat_t  want_beat;
	int unsigned draw;

	ir_ternary_pulse_distance_encoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// letters to 0..25, blank to 26, anything else -1
	function automatic int letter_index(input logic [7:0] ch);
		if (ch >= 8'h41 && ch <= 8'h5A)
			return int'(ch - 8'h41);
		if (ch >= 8'h61 && ch <= 8'h7A)
			return int'(ch - 8'h61);
		if (ch == 8'h20)
			return BLANK_INDEX;
		return -1;
	endfunction

	// wait before the next beat: idle stretches alternate with runs of none
	function automatic int unsigned draw_wait(inout bit idle_on);
		if ($urandom_range(0, 11) == 0)
			idle_on = !idle_on;
		return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	task automatic push_run(input logic [7:0] value, input int unsigned len);
		line_beat_t b;
		for (int unsigned i = 0; i < len; i++) begin
			if (sent_count >= line_limit)
				break;
			b.line_byte = value;
			b.last = 1'b0;
			line_q.push_back(b);
			sent_count = sent_count + 12'd1;
		end
	endtask

	task automatic predict_line_bytes(input msg_item_t it);
		int unsigned base;
		int idx;
		int unsigned digit;
		line_beat_t b;
		base = line_q.size();
		case (it.action)
			ACT_START: begin
				sent_count = '0;
				push_run(LINE_MARK, HEADER_MARK_LEN);
				push_run(LINE_SPACE, HEADER_GAP_LEN);
			end
			ACT_CHAR: begin
				idx = letter_index(it.char_code);
				if (idx >= 0) begin
					for (int d = 0; d < 3; d++) begin
						case (d)
							0:       digit = idx / 9;
							1:       digit = (idx % 9) / 3;
							default: digit = idx % 3;
						endcase
						push_run(LINE_MARK, DIGIT_MARK_LEN);
						push_run(LINE_SPACE, DIGIT_GAP_STEP * (digit + 1));
					end
				end
			end
			ACT_END: push_run(LINE_MARK, TRAILER_LEN);
			default: ;
		endcase
		if (line_q.size() > base) begin
			b = line_q.pop_back();
			b.last = 1'b1;
			line_q.push_back(b);
		end
	endtask

	// expectations are queued when the beat is presented, before the block
	// takes it and sends its bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (pending_q.size() != 0) begin
				next_item = pending_q.pop_front();
				predict_line_bytes(next_item);
				s_tvalid <= 1'b1;
				s_tuser <= next_item.action;
				s_tdata <= next_item.char_code;
				src_gap <= draw_wait(src_idle_on);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall <= 0;
		end else if (m_tvalid && m_tready) begin
			if (line_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual byte %02h last %b",
					$time, m_tdata, m_tlast);
				fail_count++;
			end else begin
				want_beat = line_q.pop_front();
				if (want_beat.line_byte !== m_tdata) begin
					$display("%0t: line byte mismatch, expected %02h actual %02h",
						$time, want_beat.line_byte, m_tdata);
					fail_count++;
				end
				if (want_beat.last !== m_tlast) begin
					$display("%0t: tlast mismatch, expected %b actual %b",
						$time, want_beat.last, m_tlast);
					fail_count++;
				end
			end
			draw = draw_wait(sink_idle_on);
			sink_stall <= draw;
			m_tready <= (draw == 0);
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= (sink_stall == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d bytes still expected", $time, line_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_item(input logic [1:0] action, input logic [7:0] ch,
			inout int unsigned counted);
		msg_item_t it;
		it.action = action;
		it.char_code = ch;
		pending_q.push_back(it);
		// ignored beats do not count towards the target
		if (action != ACT_UNUSED && !(action == ACT_CHAR && letter_index(ch) < 0))
			counted++;
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned r;
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		r = $urandom_range(0, BLANK_INDEX);
		if (r == BLANK_INDEX)
			return 8'h20;
		return $urandom_range(0, 1) ? 8'(8'h41 + r) : 8'(8'h61 + r);
	endfunction

	// mostly whole messages with random text, the rest loose or broken beats
	task automatic queue_random(input int unsigned target);
		int unsigned counted;
		int unsigned len;
		counted = 0;
		while (counted < target) begin
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(1, 8);
				queue_item(ACT_START, 8'($urandom_range(0, 255)), counted);
				for (int unsigned i = 0; i < len; i++)
					queue_item(ACT_CHAR, pick_char(), counted);
				if ($urandom_range(0, 7) != 0)
					queue_item(ACT_END, 8'($urandom_range(0, 255)), counted);
			end else begin
				queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), counted);
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || s_tvalid || line_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [11:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		line_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned dummy;
		dummy = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every letter range edge, blank, near misses, loose end beats
		queue_item(ACT_START, 8'h00, dummy);
		queue_item(ACT_CHAR, 8'h41, dummy);
		queue_item(ACT_CHAR, 8'h5A, dummy);
		queue_item(ACT_CHAR, 8'h61, dummy);
		queue_item(ACT_CHAR, 8'h7A, dummy);
		queue_item(ACT_CHAR, 8'h20, dummy);
		queue_item(ACT_CHAR, 8'h4D, dummy);
		queue_item(ACT_CHAR, 8'h40, dummy);
		queue_item(ACT_CHAR, 8'h5B, dummy);
		queue_item(ACT_CHAR, 8'h60, dummy);
		queue_item(ACT_CHAR, 8'h7B, dummy);
		queue_item(ACT_CHAR, 8'h00, dummy);
		queue_item(ACT_CHAR, 8'hFF, dummy);
		queue_item(ACT_CHAR, 8'h1F, dummy);
		queue_item(ACT_CHAR, 8'h21, dummy);
		queue_item(ACT_END, 8'h00, dummy);
		queue_item(ACT_UNUSED, 8'hAA, dummy);
		queue_item(ACT_UNUSED, 8'h55, dummy);
		queue_item(ACT_END, 8'hFF, dummy);
		queue_item(ACT_CHAR, 8'h62, dummy);
		queue_item(ACT_START, 8'hFF, dummy);
		queue_item(ACT_CHAR, 8'h71, dummy);
		queue_item(ACT_END, 8'h41, dummy);
		queue_random(60);
		wait_idle();

		write_limit(12'd4095);
		queue_random(60);
		wait_idle();

		// nothing gets out at all
		write_limit(12'd0);
		queue_random(20);
		wait_idle();

		write_limit(12'd1);
		queue_random(20);
		wait_idle();

		// cut inside the header space
		write_limit(12'd47);
		queue_random(40);
		wait_idle();

		write_limit(12'($urandom_range(60, 300)));
		queue_random(60);
		wait_idle();

		write_limit(LIMIT_AT_RESET);
		queue_random(50);
		wait_idle();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
